### hdl/bli_pkg.sv
// Shared types, constants and helpers for the breakpoint linear interpolator.
package bli_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 5;
    localparam int SCALE_W    = 16;
    localparam int INDEX_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SUB_W      = DATA_W + 1;

    localparam int                   SCALE_SHIFT = 8;
    localparam logic [SCALE_W-1:0]   SCALE_RESET = 16'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_SCALE = 2'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef enum logic [1:0] {
        REGION_BELOW  = 2'd0,
        REGION_INTERP = 2'd1,
        REGION_BEYOND = 2'd2,
        REGION_EMPTY  = 2'd3
    } t_region;

    typedef struct packed {
        logic [SUB_W-1:0] a;
        logic [SUB_W-1:0] b;
    } t_sub_req;

    typedef struct packed {
        logic [SUB_W-1:0] diff;
        logic             borrow;
    } t_sub_res;

    function automatic logic signed [DATA_W-1:0] sat_to_32(input logic signed [63:0] x);
        logic signed [DATA_W-1:0] y;
        if (x[63:DATA_W-1] == '0 || x[63:DATA_W-1] == '1) begin
            y = x[DATA_W-1:0];
        end else if (x[63]) begin
            y = 32'sh8000_0000;
        end else begin
            y = 32'sh7FFF_FFFF;
        end
        return y;
    endfunction

endpackage

### hdl/bli_sub.sv
// Shared 33-bit subtract/compare unit used by the search, setup and divide steps.
module bli_sub (
    input  bli_pkg::t_sub_req i_req,
    output bli_pkg::t_sub_res o_res
);
    import bli_pkg::*;

    logic [SUB_W:0] full;

    assign full         = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_res.diff   = full[SUB_W-1:0];
    assign o_res.borrow = full[SUB_W];

endmodule

### hdl/bli_mul.sv
// Shared signed multiplier with registered product, for load scaling and interpolation.
module bli_mul #(
    parameter int B_W = 17
) (
    input  logic                                  i_clk,
    input  logic signed [bli_pkg::SUB_W-1:0]      i_a,
    input  logic signed [B_W-1:0]                 i_b,
    output logic signed [bli_pkg::SUB_W+B_W-1:0]  o_prod
);
    import bli_pkg::*;

    localparam int P_W = SUB_W + B_W;

    logic signed [P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### hdl/breakpoint_linear_interpolator.sv
// Top level: breakpoint table, search/divide sequencer and result register.
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------------
//  in      | i_in_valid / o_in_stall | i_command, i_point_index, i_point_distance,
//          |                         | i_point_value, i_query_distance
//  out     | o_out_valid/i_out_stall | o_result_value, o_region
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A load beat passes through one multiply state and one table-write state.
// An evaluate beat reads one table entry per cycle in the search, then runs FRAC_BITS+1
// restoring divide steps on the shared subtractor, one multiply and one rounding step.
// An empty table skips the search and goes straight to the result.
// Reset is synchronous; the table itself is not cleared. A stalled result stays in the
// output register while the next beat is accepted; the sequencer waits there only if
// a second result is ready before the first is taken.
module breakpoint_linear_interpolator #(
    parameter int MAX_POINTS = bli_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = bli_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [bli_pkg::INDEX_W-1:0]       i_point_index,
    input  logic [bli_pkg::DATA_W-1:0]        i_point_distance,
    input  logic signed [bli_pkg::DATA_W-1:0] i_point_value,
    input  logic [bli_pkg::DATA_W-1:0]        i_query_distance,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [bli_pkg::DATA_W-1:0] o_result_value,
    output logic [1:0]                        o_region,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bli_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bli_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bli_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int RW = FRAC_BITS + 1;
    localparam int KW = $clog2(FRAC_BITS + 1);
    localparam int MB = (RW + 1 > SCALE_W + 1) ? RW + 1 : SCALE_W + 1;
    localparam int PW = SUB_W + MB;

    localparam logic signed [PW-1:0] LD_RND = PW'(1) << (SCALE_SHIFT - 1);
    localparam logic signed [PW-1:0] EV_RND = PW'(1) << (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LMUL, S_LWR, S_SCAN, S_DEN, S_NUM, S_DV, S_DIV, S_MUL, S_FIN, S_DONE
    } t_state;

    t_state r_state;

    logic [COUNT_W-1:0] r_point_count;
    logic [SCALE_W-1:0] r_value_scale;

    logic [INDEX_W-1:0]       r_pidx;
    logic [DATA_W-1:0]        r_pdist;
    logic signed [DATA_W-1:0] r_pval;
    logic [DATA_W-1:0]        r_q;
    logic [AW-1:0]            r_idx;
    logic [AW-1:0]            r_last;
    logic [DATA_W-1:0]        r_d0;
    logic [DATA_W-1:0]        r_d1;
    logic signed [DATA_W-1:0] r_v0;
    logic signed [DATA_W-1:0] r_v1;
    logic [DATA_W-1:0]        r_den;
    logic [DATA_W-1:0]        r_rem;
    logic signed [SUB_W-1:0]  r_dv;
    logic [RW-1:0]            r_ratio;
    logic [KW-1:0]            r_cnt;
    logic signed [DATA_W-1:0] r_res;
    t_region                  r_region;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_res;
    t_region                  r_out_region;

    logic [DATA_W-1:0]        mem_d [MAX_POINTS];
    logic signed [DATA_W-1:0] mem_v [MAX_POINTS];
    logic [DATA_W-1:0]        r_rd_d;
    logic signed [DATA_W-1:0] r_rd_v;
    logic [AW-1:0]            rd_addr;

    logic                     in_accept;
    logic [CW-1:0]            count_ext;
    logic [CW-1:0]            n_clamped;
    logic                     pidx_ok;

    t_sub_req                 sub_req;
    t_sub_res                 sub_res;
    logic [SUB_W-1:0]         div_a;
    logic                     hit;

    logic signed [SUB_W-1:0]  mul_a;
    logic signed [MB-1:0]     mul_b;
    logic signed [PW-1:0]     prod;

    logic signed [PW-1:0]     ld_sum;
    logic signed [PW-1:0]     ld_shift;
    logic signed [DATA_W-1:0] ld_val;
    logic signed [PW-1:0]     ev_sum;
    logic signed [PW-1:0]     ev_shift;
    logic signed [PW-1:0]     ev_tot;
    logic signed [PW-1:0]     v0_ext;

    assign o_in_stall     = (r_state != S_IDLE);
    assign in_accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_res;
    assign o_region       = r_out_region;

    assign count_ext = CW'(r_point_count);
    assign n_clamped = (count_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : count_ext;
    assign pidx_ok   = int'(r_pidx) < MAX_POINTS;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_value_scale <= SCALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_POINT_COUNT: r_point_count <= i_cfg_data[COUNT_W-1:0];
                CFG_VALUE_SCALE: r_value_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // breakpoint table
    assign rd_addr = (r_state == S_SCAN) ? r_idx + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (r_state == S_LWR && pidx_ok) begin
            mem_d[AW'(r_pidx)] <= r_pdist;
            mem_v[AW'(r_pidx)] <= ld_val;
        end
        r_rd_d <= mem_d[rd_addr];
        r_rd_v <= mem_v[rd_addr];
    end

    // shared subtractor operand select
    assign div_a = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};

    always_comb begin
        sub_req.a = {1'b0, r_rd_d};
        sub_req.b = {1'b0, r_q};
        case (r_state)
            S_DEN: begin
                sub_req.a = {1'b0, r_d1};
                sub_req.b = {1'b0, r_d0};
            end
            S_NUM: begin
                sub_req.a = {1'b0, r_q};
                sub_req.b = {1'b0, r_d0};
            end
            S_DV: begin
                sub_req.a = {r_v1[DATA_W-1], r_v1};
                sub_req.b = {r_v0[DATA_W-1], r_v0};
            end
            S_DIV: begin
                sub_req.a = div_a;
                sub_req.b = {1'b0, r_den};
            end
            default: ;
        endcase
    end

    bli_sub u_sub (
        .i_req (sub_req),
        .o_res (sub_res)
    );

    assign hit = !sub_res.borrow;

    // shared multiplier operand select
    assign mul_a = (r_state == S_MUL) ? r_dv : {r_pval[DATA_W-1], r_pval};
    assign mul_b = (r_state == S_MUL) ? MB'(r_ratio) : MB'(r_value_scale);

    bli_mul #(
        .B_W (MB)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // rounding and saturation
    assign ld_sum   = prod + LD_RND;
    assign ld_shift = ld_sum >>> SCALE_SHIFT;
    assign ld_val   = sat_to_32(64'(ld_shift));

    assign v0_ext   = PW'(r_v0);
    assign ev_sum   = prod + EV_RND;
    assign ev_shift = ev_sum >>> FRAC_BITS;
    assign ev_tot   = ev_shift + v0_ext;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_pidx  <= i_point_index;
                        r_pdist <= i_point_distance;
                        r_pval  <= i_point_value;
                        r_q     <= i_query_distance;
                        r_idx   <= '0;
                        r_last  <= AW'(n_clamped - CW'(1));
                        if (i_command == CMD_LOAD) begin
                            r_state <= S_LMUL;
                        end else if (n_clamped == '0) begin
                            r_res    <= '0;
                            r_region <= REGION_EMPTY;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_LMUL: begin
                    r_state <= S_LWR;
                end
                S_LWR: begin
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (hit && r_idx == '0) begin
                        r_res    <= r_rd_v;
                        r_region <= REGION_BELOW;
                        r_state  <= S_DONE;
                    end else if (hit) begin
                        r_d1    <= r_rd_d;
                        r_v1    <= r_rd_v;
                        r_state <= S_DEN;
                    end else if (r_idx == r_last) begin
                        r_res    <= r_rd_v;
                        r_region <= REGION_BEYOND;
                        r_state  <= S_DONE;
                    end else begin
                        r_d0  <= r_rd_d;
                        r_v0  <= r_rd_v;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DEN: begin
                    r_den   <= sub_res.diff[DATA_W-1:0];
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_rem   <= sub_res.diff[DATA_W-1:0];
                    r_state <= S_DV;
                end
                S_DV: begin
                    r_dv    <= sub_res.diff;
                    r_cnt   <= '0;
                    r_ratio <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (hit) begin
                        r_rem   <= sub_res.diff[DATA_W-1:0];
                        r_ratio <= {r_ratio[RW-2:0], 1'b1};
                    end else begin
                        r_rem   <= div_a[DATA_W-1:0];
                        r_ratio <= {r_ratio[RW-2:0], 1'b0};
                    end
                    if (r_cnt == KW'(FRAC_BITS)) begin
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res    <= sat_to_32(64'(ev_tot));
                    r_region <= REGION_INTERP;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_res    <= r_res;
                        r_out_region <= r_region;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("block not busy after an accepted beat");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_command == CMD_LOAD && !o_out_valid) |=> !o_out_valid)
        else $error("load beat produced a result");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_region == REGION_EMPTY) |-> (o_result_value == '0))
        else $error("empty-table result is not zero");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= KW'(FRAC_BITS)))
        else $error("divide step count out of range");
`endif

endmodule
